// ----- src/crc32_byte_stream_top_macros.svh -----
// assertion macros used by the crc core of the crc32 byte stream block
`ifndef CRC32_BYTE_STREAM_TOP_MACROS_SVH
`define CRC32_BYTE_STREAM_TOP_MACROS_SVH

// checked at every edge, reset included
`define CRCB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// checked only outside reset
`define CRCB_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ----- src/crcb_pkg.sv -----
// types, constants, and the byte fold and byte swap functions of the crc32 byte stream block
`default_nettype none

package crcb_pkg;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_INIT = 32'hffffffff;

  // one registered request between the input stage and the crc core
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } crcb_req_t;

  // fold one byte into the running crc, lsb first
  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                input logic [7:0]  data);
    logic [31:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ data[k];
      crc = {1'b0, crc[31:1]} ^ (fb ? CRC_POLY : 32'h0);
    end
    return crc;
  endfunction

  function automatic logic [31:0] crc_swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

// ----- src/crcb_in_stage.sv -----
// input register stage of the crc32 byte stream block
`default_nettype none

module crcb_in_stage
  import crcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_last,
  output crcb_req_t       req,
  input  wire logic       take
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  // register is free when empty or when the core takes it this cycle
  assign in_stall = valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data_byte;
      last_r <= in_last;
    end
  end

  assign req = '{valid: valid_r, data: data_r, last: last_r};

endmodule

`default_nettype wire

// ----- src/crcb_core.sv -----
// running crc register, byte fold and result register
`default_nettype none

module crcb_core
  import crcb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire crcb_req_t  req,
  output logic            take,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [31:0]     out_crc_value
);

`include "crc32_byte_stream_top_macros.svh"

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;
  logic [31:0] fold;
  logic        out_valid_r;
  logic [31:0] out_crc_r;

  // a last byte needs the result register free or draining
  assign take = req.valid && (!req.last || !out_valid_r || !out_stall);

  assign fold    = crc_fold_byte(crc_r, req.data);
  assign crc_nxt = req.last ? CRC_INIT : fold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        crc_r <= crc_nxt;
      end
      if (take && req.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && req.last) begin
      out_crc_r <= ~crc_swap_bytes(fold);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  `CRCB_ASSERT(a_reset_crc, !rst_n |=> crc_r == CRC_INIT, "crc not all ones after reset")
  `CRCB_ASSERT_RUN(a_last_gives_result, take && req.last |=> out_valid_r,
                   "last byte taken without a result")
  `CRCB_ASSERT_RUN(a_last_restarts, take && req.last |=> crc_r == CRC_INIT,
                   "crc not restarted after last byte")
  `CRCB_ASSERT_RUN(a_no_overwrite, out_valid_r && out_stall |-> !(take && req.last),
                   "pending result overwritten")

endmodule

`default_nettype wire

// ----- src/crc32_byte_stream_top.sv -----
// crc32 byte stream: accepts one byte per cycle unless in_stall is high, gives a crc per message
// an accepted last byte is registered in the input stage, then its crc in the result register, which drives out_valid
// throughput: one byte per cycle while not stalled, set by the combinational 8-bit crc fold
// a result stalled at the output holds the core only when the next last byte arrives
// synchronous active-low reset empties both registers and sets the crc to all ones
`default_nettype none

module crc32_byte_stream_top
  import crcb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_crc_value
);

  crcb_req_t req;
  logic      take;

  crcb_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .req          (req),
    .take         (take)
  );

  crcb_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

endmodule

`default_nettype wire

// ----- bench/tb_crc32_byte_stream_top.sv -----
// self-checking testbench for the crc32 byte stream block: directed table then random messages
module tb_crc32_byte_stream_top;

  localparam logic [31:0] POLY_REFL      = 32'hedb88320;
  localparam logic [31:0] CRC_SEED       = 32'hffffffff;
  localparam int          NUM_DIRECTED   = 23;
  localparam int          HOLD_CYCLES    = 120;
  localparam int          WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        known;
    logic [31:0] crc;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_crc_value;

  logic [31:0] msg_crc = CRC_SEED;
  logic [31:0] crc_expect_q[$];
  logic [31:0] want_crc;
  int          fail_count = 0;
  int          idle_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  logic        hold_req = 1'b0;
  dir_row_t    directed_rows [0:NUM_DIRECTED-1];

  crc32_byte_stream_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_crc_value (out_crc_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // reflected crc update, byte folded into the low bits first
  function automatic logic [31:0] crc_after_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] r;
    r = acc ^ {24'h0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ POLY_REFL) : (r >> 1);
    return r;
  endfunction

  // offers one request and records the expected crc once it is taken
  task automatic send_byte(input logic [7:0] d, input logic l, input logic known,
                           input logic [31:0] known_crc);
    logic [31:0] exp_crc;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last      <= l;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    msg_crc = crc_after_byte(msg_crc, d);
    if (l) begin
      exp_crc = known ? known_crc
                : ~{msg_crc[7:0], msg_crc[15:8], msg_crc[23:16], msg_crc[31:24]};
      crc_expect_q = {crc_expect_q, exp_crc};
      msg_crc = CRC_SEED;
    end
  endtask

  task automatic send_random_msgs(input int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
      for (int k = 0; k < len; k++) send_byte(8'($urandom_range(255)), k == len - 1, 1'b0, '0);
      sent += len;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (crc_expect_q.size() == 0) begin
        $error("crc_value with no request pending: actual %08h", out_crc_value);
        fail_count++;
      end else begin
        want_crc = crc_expect_q.pop_front();
        if (out_crc_value !== want_crc) begin
          $error("crc_value mismatch: expected %08h, actual %08h", want_crc, out_crc_value);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // single bytes at both extremes, an all-ones word, zeros, the standard check string, two more single bytes, a pair
    directed_rows = '{
      '{8'h00, 1'b1, 1'b1, 32'h8def02d2},
      '{8'hff, 1'b1, 1'b1, 32'h000000ff},
      '{8'hff, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b0, 1'b0, 32'h0},
      '{8'hff, 1'b1, 1'b1, 32'hffffffff},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b0, 32'h0},
      '{8'h31, 1'b0, 1'b0, 32'h0},
      '{8'h32, 1'b0, 1'b0, 32'h0},
      '{8'h33, 1'b0, 1'b0, 32'h0},
      '{8'h34, 1'b0, 1'b0, 32'h0},
      '{8'h35, 1'b0, 1'b0, 32'h0},
      '{8'h36, 1'b0, 1'b0, 32'h0},
      '{8'h37, 1'b0, 1'b0, 32'h0},
      '{8'h38, 1'b0, 1'b0, 32'h0},
      '{8'h39, 1'b1, 1'b1, 32'h2639f4cb},
      '{8'h80, 1'b1, 1'b0, 32'h0},
      '{8'h01, 1'b1, 1'b0, 32'h0},
      '{8'haa, 1'b0, 1'b0, 32'h0},
      '{8'h55, 1'b1, 1'b0, 32'h0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_byte(directed_rows[i].data, directed_rows[i].last,
                directed_rows[i].known, directed_rows[i].crc);

    tx_idle_pct = 35;
    rx_idle_pct = 60;
    send_random_msgs(600);
    wait_drained();

    tx_idle_pct = 60;
    rx_idle_pct = 35;
    send_random_msgs(600);

    // back-to-back one-byte messages against a long output hold fill the pipe
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req <= 1'b1;
    for (int i = 0; i < 150; i++) send_byte(8'($urandom_range(255)), 1'b1, 1'b0, '0);
    send_random_msgs(450);

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/crcb_pkg.sv
src/crcb_in_stage.sv
src/crcb_core.sv
src/crc32_byte_stream_top.sv
bench/tb_crc32_byte_stream_top.sv
